/* rtl/stbs_pkg.sv */
package stbs_pkg;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_state;

    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 10;
    localparam int POSITION_W = 10;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register word index within the configuration space
    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic load;     // write one table entry
        logic init;     // latch key and set bounds to the first entry_count entries, clamped to DEPTH
        logic step;     // narrow bounds from the current compare
        logic finish;   // register the result and raise the strobe
    } t_dp_cmd;

    typedef struct packed {
        logic empty;    // interval holds no entries
        logic match;    // probed entry equals key
    } t_dp_status;

endpackage

/* rtl/stbs_regs.sv */
module stbs_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [stbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [stbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [stbs_pkg::COUNT_W-1:0]        o_entry_count
);
    import stbs_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    logic [COUNT_W-1:0] n_entry_count;
    logic               wr_en;
    logic [0:0]         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1 -: 1];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        n_entry_count = r_entry_count;
        if (wr_en && reg_sel == REG_ENTRY_COUNT) begin
            n_entry_count = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else begin
            r_entry_count <= n_entry_count;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ENTRY_COUNT: prdata = APB_DATA_W'(r_entry_count);
            default:         prdata = '0;
        endcase
    end

    assign o_entry_count = r_entry_count;

endmodule

/* rtl/stbs_ctrl.sv */
module stbs_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_op,
    input  stbs_pkg::t_dp_status    i_status,
    output stbs_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);
    import stbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && t_op'(i_op) == OP_SEARCH) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_status.empty || i_status.match) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start && t_op'(i_op) == OP_LOAD;
                o_cmd.init = i_start && t_op'(i_op) == OP_SEARCH;
            end
            ST_PROBE: begin
                o_busy       = 1'b1;
                o_cmd.finish = i_status.empty | i_status.match;
                o_cmd.step   = ~(i_status.empty | i_status.match);
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

/* rtl/stbs_dp.sv */
module stbs_dp #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stbs_pkg::t_dp_cmd                   i_cmd,
    input  logic [stbs_pkg::COUNT_W-1:0]        i_entry_count,
    input  logic [stbs_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [stbs_pkg::VALUE_W-1:0] i_value,
    input  logic signed [stbs_pkg::KEY_W-1:0]   i_key,
    output stbs_pkg::t_dp_status                o_status,
    output logic                                o_done,
    output logic                                o_found,
    output logic [stbs_pkg::POSITION_W-1:0]     o_position
);
    import stbs_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int BW   = AW + 1;                       // bounds reach DEPTH
    localparam int SW   = BW + 1;                       // bound sum
    localparam int LW   = (BW > COUNT_W) ? BW : COUNT_W;
    localparam int CMPW = (DATA_WIDTH > KEY_W) ? DATA_WIDTH : KEY_W;
    localparam int IW   = (INDEX_W > AW + 1) ? INDEX_W : AW + 1;

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic signed [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]                r_mid;
    logic [BW-1:0]                r_lo;
    logic [BW-1:0]                r_hi;      // one past the last candidate
    logic [BW-1:0]                n_lo;
    logic [BW-1:0]                n_hi;
    logic signed [KEY_W-1:0]      r_key;
    logic                         r_done;
    logic                         r_found;
    logic [POSITION_W-1:0]        r_position;

    logic [BW-1:0]                count_clamped;
    logic [SW-1:0]                sum;
    logic [AW-1:0]                rd_addr;
    logic signed [CMPW-1:0]       value_ext;
    logic signed [CMPW-1:0]       entry_ext;
    logic signed [CMPW-1:0]       key_ext;
    logic                         less;
    logic                         wr_ok;

    assign count_clamped = (LW'(i_entry_count) > LW'(DEPTH)) ? BW'(DEPTH) : BW'(i_entry_count);

    // store the low DATA_WIDTH bits of the sign-extended value
    assign value_ext = CMPW'(i_value);
    assign wr_ok     = IW'(i_index) < IW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[AW'(i_index)] <= value_ext[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.init) begin
            n_lo = '0;
            n_hi = count_clamped;
        end else if (i_cmd.step) begin
            if (less) begin
                n_lo = BW'(r_mid) + BW'(1);
            end else begin
                n_hi = BW'(r_mid);
            end
        end
    end

    // probe floor((lo + last) / 2) of the next interval
    assign sum     = SW'(n_lo) + SW'(n_hi) - SW'(1);
    assign rd_addr = sum[AW:1];

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        r_mid   <= rd_addr;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        if (i_cmd.init) begin
            r_key <= i_key;
        end
    end

    assign entry_ext = CMPW'(r_rdata);
    assign key_ext   = CMPW'(r_key);
    assign less      = entry_ext < key_ext;

    assign o_status.empty = r_lo >= r_hi;
    assign o_status.match = entry_ext == key_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found    <= ~o_status.empty & o_status.match;
            r_position <= (~o_status.empty & o_status.match) ? POSITION_W'(r_mid) : '0;
        end
    end

    assign o_done     = r_done;
    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

/* rtl/sorted_table_binary_search_core.sv */
// Binary search over a table of signed entries kept in ascending order. A load
// request (op 0) writes one entry in the cycle it is accepted and gives no
// result; busy stays low, so loads can follow each other every cycle. A search
// request (op 1) probes the first entry_count entries (clamped to DEPTH), one
// probe per clock: the table memory read and the key compare form the loop
// that sets the rate. busy is high while the search probes, and the result
// appears on o_found/o_position with o_done high for one cycle as busy falls;
// a new request may be started in that same cycle. The receiver cannot stall
// the result, so it must capture it whenever o_done is high. The table powers
// up undefined: search only over entries that have been loaded.
module sorted_table_binary_search_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [stbs_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [stbs_pkg::VALUE_W-1:0] i_value,
    input  logic signed [stbs_pkg::KEY_W-1:0]   i_key,
    output logic                                o_done,
    output logic                                o_found,
    output logic [stbs_pkg::POSITION_W-1:0]     o_position,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [stbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [stbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import stbs_pkg::*;

    logic [COUNT_W-1:0] entry_count;
    t_dp_cmd            cmd;
    t_dp_status         status;

    stbs_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_entry_count (entry_count)
    );

    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    stbs_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_entry_count (entry_count),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_key         (i_key),
        .o_status      (status),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 16;
    localparam int PHASE_ITEMS = 20;
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * REG_ENTRY_COUNT);
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } t_lookup;

    typedef struct {
        t_op                        op;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
        logic signed [KEY_W-1:0]    key;
        int                         new_count;  // -1 keeps the current count
        bit                         typed;
        t_lookup                    answer;
    } t_plan_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_op;
    logic [INDEX_W-1:0]             i_index;
    logic signed [VALUE_W-1:0]      i_value;
    logic signed [KEY_W-1:0]        i_key;
    logic                           o_done;
    logic                           o_found;
    logic [POSITION_W-1:0]          o_position;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [APB_ADDR_W-1:0]          paddr;
    logic [APB_DATA_W-1:0]          pwdata;
    logic [APB_DATA_W-1:0]          prdata;
    logic                           pready;

    logic signed [VALUE_W-1:0]      shadow_table [TABLE_DEPTH];
    int                             shadow_count;
    t_lookup                        lookup_q [$];
    t_lookup                        oldest;
    int                             mismatches;
    int                             cycles = 0;

    sorted_table_binary_search_core #(
        .DEPTH      (TABLE_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_index    (i_index),
        .i_value    (i_value),
        .i_key      (i_key),
        .o_done     (o_done),
        .o_found    (o_found),
        .o_position (o_position),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Binary search over the shadow table, probing exactly as the block does.
    function automatic t_lookup search_table(input logic signed [KEY_W-1:0] key);
        int      lo;
        int      hi;
        int      mid;
        bit      hit;
        t_lookup res;
        res = '0;
        hit = 1'b0;
        lo  = 0;
        hi  = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count) - 1;
        while (!hit && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key) begin
                hit          = 1'b1;
                res.found    = 1'b1;
                res.position = POSITION_W'(mid);
            end else if (shadow_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (lookup_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b position=%0d",
                         $time, o_found, o_position);
                mismatches++;
            end else begin
                oldest = lookup_q.pop_front();
                if (o_found !== oldest.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, oldest.found, o_found);
                    mismatches++;
                end
                if (o_position !== oldest.position) begin
                    $display("%0t: position mismatch expected %0d actual %0d",
                             $time, oldest.position, o_position);
                    mismatches++;
                end
            end
        end
    end

    // Present one request, hold it until accepted, then update the shadow state.
    task automatic issue_request(input t_op op, input logic [INDEX_W-1:0] idx,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic signed [KEY_W-1:0] key,
                                 input bit typed, input t_lookup answer,
                                 input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_index <= idx;
        i_value <= val;
        i_key   <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (op == OP_LOAD) begin
            shadow_table[idx] = val;
        end else if (typed) begin
            lookup_q.push_back(answer);
        end else begin
            lookup_q.push_back(search_table(key));
        end
    endtask

    // Drain, then write entry_count and read it back.
    task automatic program_count(input int cnt);
        logic [COUNT_W-1:0] cnt_bits;
        cnt_bits = cnt[COUNT_W-1:0];
        start <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DATA_W'(cnt_bits);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_count = int'(cnt_bits);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_W'(cnt_bits)) begin
            $display("%0t: entry_count readback expected %0d actual %0d",
                     $time, cnt_bits, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_plan_row ld(input int idx, input logic signed [VALUE_W-1:0] val);
        t_plan_row r;
        r.op        = OP_LOAD;
        r.index     = INDEX_W'(idx);
        r.value     = val;
        r.key       = '0;
        r.new_count = -1;
        r.typed     = 1'b0;
        r.answer    = '0;
        return r;
    endfunction

    function automatic t_plan_row sr(input logic signed [KEY_W-1:0] key, input int cnt,
                                     input bit typed, input bit found, input int pos);
        t_plan_row r;
        r.op              = OP_SEARCH;
        r.index           = '0;
        r.value           = '0;
        r.key             = key;
        r.new_count       = cnt;
        r.typed           = typed;
        r.answer.found    = found;
        r.answer.position = POSITION_W'(pos);
        return r;
    endfunction

    initial begin : stimulus
        t_plan_row                 plan [$];
        int                        counts [8];
        int                        idle_by_mode [4];
        int                        n_eff;
        int                        idx;
        int                        pick;
        int                        idle;
        longint                    acc;
        longint                    lo_v;
        longint                    hi_v;
        logic signed [VALUE_W-1:0] val;
        logic signed [KEY_W-1:0]   key;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_op       <= OP_LOAD;
        i_index    <= '0;
        i_value    <= '0;
        i_key      <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        mismatches = 0;
        shadow_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count is zero after reset: nothing can be found
        plan.push_back(sr(32'sd0, -1, 1, 0, 0));
        plan.push_back(sr(VAL_MIN, -1, 1, 0, 0));
        plan.push_back(ld(0, VAL_MIN));
        plan.push_back(ld(1, -32'sd1000));
        plan.push_back(ld(2, -32'sd1));
        plan.push_back(ld(3, 32'sd0));
        plan.push_back(ld(4, 32'sd1));
        plan.push_back(ld(5, 32'sd5));
        plan.push_back(ld(6, 32'sd1000));
        plan.push_back(ld(7, VAL_MAX));
        plan.push_back(sr(VAL_MIN, 8, 1, 1, 0));
        plan.push_back(sr(VAL_MAX, -1, 1, 1, 7));
        plan.push_back(sr(32'sd0, -1, 1, 1, 3));
        plan.push_back(sr(-32'sd1, -1, 1, 1, 2));
        plan.push_back(sr(32'sd2, -1, 1, 0, 0));
        plan.push_back(sr(VAL_MIN + 32'sd1, -1, 1, 0, 0));
        plan.push_back(sr(VAL_MIN, 1, 1, 1, 0));
        plan.push_back(sr(32'sd5, -1, 1, 0, 0));
        plan.push_back(ld(1023, VAL_MAX));
        // break the ordering: probes still follow the bounds rules
        plan.push_back(ld(4, -32'sd5));
        plan.push_back(sr(32'sd1, 8, 0, 0, 0));
        plan.push_back(sr(-32'sd5, -1, 0, 0, 0));

        foreach (plan[i]) begin
            if (plan[i].new_count >= 0) program_count(plan[i].new_count);
            issue_request(plan[i].op, plan[i].index, plan[i].value, plan[i].key,
                          plan[i].typed, plan[i].answer, 0);
        end

        // fill the whole table in ascending order, with some duplicates
        acc = longint'(VAL_MIN);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == TABLE_DEPTH - 1) acc = longint'(VAL_MAX);
            else if (i != 0 && $urandom_range(0, 15) != 0)
                acc = acc + longint'($urandom_range(0, 7000000));
            if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
            issue_request(OP_LOAD, INDEX_W'(i), VALUE_W'(acc), KEY_W'($urandom),
                          1'b0, '0, 0);
        end

        counts       = '{1024, 2047, 0, 1, 1025, 2, 513, 0};
        counts[7]    = $urandom_range(3, 1023);
        // mode 2 is receiver stall, which this interface cannot apply
        idle_by_mode = '{0, 77, 0, 11};

        for (int ph = 0; ph < 8; ph++) begin
            program_count(counts[ph]);
            idle  = idle_by_mode[ph % 4];
            n_eff = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (lookup_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                    start <= 1'b0;
                    while (lookup_q.size() != 0) @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                idx  = $urandom_range(0, TABLE_DEPTH - 1);
                if (pick < 16) begin
                    val  = VALUE_W'($urandom);
                    lo_v = (idx == 0) ? longint'(VAL_MIN) : longint'(shadow_table[idx - 1]);
                    hi_v = (idx == TABLE_DEPTH - 1) ? longint'(VAL_MAX)
                                                    : longint'(shadow_table[idx + 1]);
                    // for pick below 12, keep the order where the neighbors allow it
                    if (pick < 12 && lo_v <= hi_v)
                        val = VALUE_W'(lo_v + longint'($urandom) % (hi_v - lo_v + 1));
                    issue_request(OP_LOAD, INDEX_W'(idx), val, KEY_W'($urandom),
                                  1'b0, '0, idle);
                end else begin
                    pick = $urandom_range(0, 9);
                    key  = KEY_W'($urandom);
                    if (pick <= 6 && n_eff > 0) begin
                        key = shadow_table[$urandom_range(0, n_eff - 1)];
                        if (pick == 6) key = $urandom_range(0, 1) ? key + 1 : key - 1;
                    end else if (pick == 7) begin
                        key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                    end
                    issue_request(OP_SEARCH, INDEX_W'($urandom), VALUE_W'($urandom), key,
                                  1'b0, '0, idle);
                end
            end
        end

        start <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT * 2) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
